>>> design/mmr_pkg.sv
// Shared constants, payload types and codes of the min-max rescaling block.
`default_nettype none

package mmr_pkg;

  localparam int MAX_LENGTH   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int EFF_WIDTH    = (SAMPLE_WIDTH > 32) ? 32 : SAMPLE_WIDTH;

  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int MAG_W      = 33;
  localparam int PROD_W     = EFF_WIDTH + MAG_W;
  localparam int QUOT_W     = 33;
  localparam int MUL_CNT_W  = $clog2(EFF_WIDTH);
  localparam int DIV_CNT_W  = $clog2(QUOT_W);
  localparam int SUM_W      = 35;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (EFF_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [0:0] {
    CFG_TARGET_LOW  = 1'b0,
    CFG_TARGET_HIGH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] scaled_value;
    logic               last_out;
    logic               overflow;
  } out_beat_t;

endpackage

`default_nettype wire

>>> design/min_max_rescale.sv
// Top level of the min-max rescaling block: sample buffer, range tracking and sequencer.
//
// Samples enter one per beat on in_beat_i, taken at a rising edge with start high and
// busy low. A beat without is_last leaves busy low. The beat with is_last closes the
// vector: busy rises and the block emits every stored sample in order, rescaled from
// the data range onto target_low..target_high and saturated. Each result is shown on
// out_beat_o for one cycle with out_strobe_o high; the receiver cannot hold results
// off, so none is ever delayed by it. Each sample passes the buffer read, the bit-serial
// multiplier, the bit-serial divider and the output register in turn, with the
// multiplier working on the next sample while the divider works on the current one.
// busy falls as the last result of the vector is shown, and the next vector may start
// in that cycle. Samples beyond the buffer depth are dropped and set a sticky overflow
// flag that every later result carries until reset. Configuration writes on cfg_we_i
// take effect at once; the user must make them while busy is low, as the block itself
// does not enforce this.
// Reset empties the buffer count, clears the flag and loads the reset targets;
// the buffer contents themselves are not cleared.
`default_nettype none

module min_max_rescale (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire mmr_pkg::in_beat_t    in_beat_i,
  input  wire logic                 cfg_we_i,
  input  wire mmr_pkg::cfg_reg_e    cfg_idx_i,
  input  wire logic [31:0]          cfg_wdata_i,
  output logic                      out_strobe_o,
  output mmr_pkg::out_beat_t        out_beat_o
);

  localparam int EW = mmr_pkg::EFF_WIDTH;
  localparam int NW = mmr_pkg::CNT_W;
  localparam int AW = mmr_pkg::ADDR_W;
  localparam int MW = mmr_pkg::MAG_W;
  localparam int SW = mmr_pkg::SUM_W;
  localparam logic [NW-1:0] DEPTH = NW'(mmr_pkg::MAX_LENGTH);

  mmr_pkg::state_e state_q, state_d;

  logic signed [31:0] tl_q, th_q;
  logic [NW-1:0]      cnt_q, cnt_d;
  logic [NW-1:0]      n_q, n_d;
  logic [NW-1:0]      issue_q, issue_d;
  logic signed [EW-1:0] min_q, min_d, max_q, max_d;
  logic               drop_q, drop_d;
  logic               rd_pend_q;
  logic               out_valid_q;
  mmr_pkg::out_beat_t out_beat_q;

  logic signed [EW-1:0] mem [mmr_pkg::MAX_LENGTH];
  logic signed [EW-1:0] rd_data_q;
  logic               rd_last_q, mul_last_q, div_last_q;
  logic [EW-1:0]      span_q;
  logic [MW-1:0]      mag_q;
  logic               neg_q, zero_q;

  logic signed [EW-1:0] x;
  logic               has_room;
  logic               mem_we, rd_req, setup_en, mul_take, div_start;
  logic               mul_running, mul_full, div_running, div_done;
  logic [mmr_pkg::PROD_W-1:0] prod;
  logic [mmr_pkg::QUOT_W-1:0] quot;
  logic [EW:0]        diff_w, span_w;
  logic signed [MW-1:0] rng;
  logic signed [SW-1:0] tl_ext, q_ext, delta, sum, sat;

  assign x        = in_beat_i.sample_value[EW-1:0];
  assign has_room = (cnt_q < DEPTH);
  assign busy     = (state_q != mmr_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= 32'sd0;
      th_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmr_pkg::CFG_TARGET_LOW:  tl_q <= cfg_wdata_i;
        mmr_pkg::CFG_TARGET_HIGH: th_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    issue_d   = issue_q;
    min_d     = min_q;
    max_d     = max_q;
    drop_d    = drop_q;
    mem_we    = 1'b0;
    rd_req    = 1'b0;
    setup_en  = 1'b0;
    mul_take  = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      mmr_pkg::ST_IDLE: begin
        if (start) begin
          if (has_room) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + NW'(1);
            if (cnt_q == '0) begin
              min_d = x;
              max_d = x;
            end else begin
              if (x < min_q) min_d = x;
              if (x > max_q) max_d = x;
            end
          end else begin
            drop_d = 1'b1;
          end
          if (in_beat_i.is_last) begin
            n_d     = has_room ? cnt_q + NW'(1) : cnt_q;
            cnt_d   = '0;
            state_d = mmr_pkg::ST_SETUP;
          end
        end
      end
      mmr_pkg::ST_SETUP: begin
        setup_en = 1'b1;
        issue_d  = '0;
        state_d  = mmr_pkg::ST_RUN;
      end
      mmr_pkg::ST_RUN: begin
        mul_take  = mul_full && !div_running;
        div_start = mul_take;
        if ((issue_q != n_q) && !rd_pend_q && !mul_running && (!mul_full || mul_take)) begin
          rd_req  = 1'b1;
          issue_d = issue_q + NW'(1);
        end
        if (div_done && div_last_q) begin
          state_d = mmr_pkg::ST_IDLE;
        end
      end
      default: state_d = mmr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmr_pkg::ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      issue_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      drop_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      issue_q     <= issue_d;
      min_q       <= min_d;
      max_q       <= max_d;
      drop_q      <= drop_d;
      rd_pend_q   <= rd_req;
      out_valid_q <= div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= x;
    end
    if (rd_req) begin
      rd_data_q <= mem[issue_q[AW-1:0]];
      rd_last_q <= (issue_d == n_q);
    end
  end

  assign span_w = {max_q[EW-1], max_q} - {min_q[EW-1], min_q};
  assign rng    = {th_q[31], th_q} - {tl_q[31], tl_q};

  always_ff @(posedge clk_i) begin
    if (setup_en) begin
      span_q <= span_w[EW-1:0];
      zero_q <= (span_w[EW-1:0] == '0);
      neg_q  <= rng[MW-1];
      mag_q  <= rng[MW-1] ? MW'(-rng) : MW'(rng);
    end
    if (rd_pend_q) begin
      mul_last_q <= rd_last_q;
    end
    if (div_start) begin
      div_last_q <= mul_last_q;
    end
  end

  assign diff_w = {rd_data_q[EW-1], rd_data_q} - {min_q[EW-1], min_q};

  mmr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rd_pend_q),
    .a_i       (diff_w[EW-1:0]),
    .b_i       (mag_q),
    .take_i    (mul_take),
    .running_o (mul_running),
    .full_o    (mul_full),
    .prod_o    (prod)
  );

  mmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (span_q),
    .running_o  (div_running),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // A flat data range maps every sample onto the lower target.
  assign tl_ext = {{(SW-32){tl_q[31]}}, tl_q};
  assign q_ext  = {{(SW-mmr_pkg::QUOT_W){1'b0}}, quot};
  assign delta  = neg_q ? -q_ext : q_ext;
  assign sum    = zero_q ? tl_ext : tl_ext + delta;
  assign sat    = (sum > mmr_pkg::SAT_HI) ? mmr_pkg::SAT_HI :
                  (sum < mmr_pkg::SAT_LO) ? mmr_pkg::SAT_LO : sum;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      out_beat_q.scaled_value <= sat[31:0];
      out_beat_q.last_out     <= div_last_q;
      out_beat_q.overflow     <= drop_q;
    end
  end

  assign out_strobe_o = out_valid_q;
  assign out_beat_o   = out_beat_q;

endmodule

`default_nettype wire

>>> design/mmr_mul.sv
// Bit-serial shift-and-add multiplier for the rescaling product.
`default_nettype none

module mmr_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mmr_pkg::EFF_WIDTH-1:0] a_i,
  input  wire logic [mmr_pkg::MAG_W-1:0]     b_i,
  input  wire logic                          take_i,
  output logic                               running_o,
  output logic                               full_o,
  output logic [mmr_pkg::PROD_W-1:0]         prod_o
);

  localparam int EW = mmr_pkg::EFF_WIDTH;
  localparam int MW = mmr_pkg::MAG_W;
  localparam int PW = mmr_pkg::PROD_W;
  localparam int CW = mmr_pkg::MUL_CNT_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(EW - 1);

  logic          run_q;
  logic          full_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] acc_q;
  logic [MW-1:0] b_q;
  logic [MW:0]   sum;
  logic [PW-1:0] step;

  assign sum  = {1'b0, acc_q[PW-1:EW]} + (acc_q[0] ? {1'b0, b_q} : '0);
  assign step = {sum, acc_q[EW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          full_q <= 1'b1;
        end
      end
      if (take_i) begin
        full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{MW{1'b0}}, a_i};
      b_q   <= b_i;
    end else if (run_q) begin
      acc_q <= step;
    end
  end

  assign running_o = run_q;
  assign full_o    = full_q;
  assign prod_o    = acc_q;

endmodule

`default_nettype wire

>>> design/mmr_div.sv
// Radix-2 restoring divider that yields one quotient bit per cycle.
`default_nettype none

module mmr_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mmr_pkg::PROD_W-1:0]    dividend_i,
  input  wire logic [mmr_pkg::EFF_WIDTH-1:0] divisor_i,
  output logic                               running_o,
  output logic                               done_o,
  output logic [mmr_pkg::QUOT_W-1:0]         quot_o
);

  localparam int EW = mmr_pkg::EFF_WIDTH;
  localparam int QW = mmr_pkg::QUOT_W;
  localparam int CW = mmr_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

  logic          run_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [EW-1:0] rem_q;
  logic [EW-1:0] dv_q;
  logic [QW-1:0] sh_q;
  logic [EW+1:0] trial;
  logic          ge;
  logic [EW-1:0] rem_next;

  // The remainder starts below the divisor, so the quotient fits in QW bits.
  assign trial    = {1'b0, rem_q, sh_q[QW-1]} - {2'b00, dv_q};
  assign ge       = ~trial[EW+1];
  assign rem_next = ge ? trial[EW-1:0] : {rem_q[EW-2:0], sh_q[QW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[mmr_pkg::PROD_W-1:QW];
      sh_q  <= dividend_i[QW-1:0];
      dv_q  <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_next;
      sh_q  <= {sh_q[QW-2:0], ge};
    end
  end

  assign running_o = run_q;
  assign done_o    = done_q;
  assign quot_o    = sh_q;

endmodule

`default_nettype wire

>>> design/mmr_checker.sv
// Port-level assertions for the min-max rescaling block and their bind.
`default_nettype none

module mmr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire mmr_pkg::in_beat_t  in_beat_i,
  input wire logic               out_strobe_o,
  input wire mmr_pkg::out_beat_t out_beat_o
);

  a_strobe_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |=> !out_strobe_o)
    else $error("Result beats arrived in consecutive cycles.");

  a_more_to_come: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !out_beat_o.last_out) |-> busy)
    else $error("Block went idle before the final result beat.");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && out_beat_o.last_out) |-> !busy)
    else $error("Block still busy on the final result beat.");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_beat_i.is_last) |=> busy)
    else $error("Closing beat did not start the output run.");

endmodule

bind min_max_rescale mmr_checker u_mmr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .in_beat_i    (in_beat_i),
  .out_strobe_o (out_strobe_o),
  .out_beat_o   (out_beat_o)
);

`default_nettype wire
